// ----- sv/mpp_pkg.sv -----
// Package for the max-plus matrix product block.
// Holds beat types, register indexes, cell control types and the saturating add.
// No dependencies.
`default_nettype none

package mpp_pkg;

    localparam int VALUE_WIDTH = 32;
    localparam int IDX_A_W     = 8;
    localparam int IDX_B_W     = 3;
    localparam int DIM_W       = 4;
    localparam int CFG_IDX_W   = 4;

    typedef logic signed [VALUE_WIDTH-1:0] t_value;

    localparam t_value VMIN     = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
    localparam t_value VMAX     = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
    localparam t_value VMIN_FIN = {1'b1, {(VALUE_WIDTH-2){1'b0}}, 1'b1};

    typedef enum logic [0:0] {
        CMD_LOAD_B = 1'b0,
        CMD_A_ELEM = 1'b1
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_INNER_DIM = 4'd0,
        CFG_N_COLS    = 4'd1
    } t_cfg_idx;

    typedef struct packed {
        t_cmd                 cmd;
        logic [IDX_A_W-1:0]   index_a;
        logic [IDX_B_W-1:0]   index_b;
        t_value               value;
    } t_in_beat;

    typedef struct packed {
        logic [IDX_A_W-1:0]   row;
        logic [IDX_B_W-1:0]   col;
        t_value               result;
        logic                 last;
    } t_out_beat;

    typedef struct packed {
        logic                 a_en;
        logic                 first;
        logic                 drain_load;
        logic                 shift;
        logic                 b_we;
        logic [IDX_B_W-1:0]   b_col;
        logic [IDX_B_W-1:0]   b_row;
        logic [IDX_B_W-1:0]   a_k;
        logic [DIM_W-1:0]     n_cols;
    } t_cell_ctl;

    typedef struct packed {
        logic                 v;
        logic [IDX_B_W-1:0]   col;
        logic                 last;
        t_value               res;
    } t_slot;

    // epsilon absorbs; finite sums saturate and never reach epsilon
    function automatic t_value trop_add(input t_value a, input t_value b);
        logic [VALUE_WIDTH:0] sum;
        t_value               res;
        sum = {a[VALUE_WIDTH-1], a} + {b[VALUE_WIDTH-1], b};
        if (a == VMIN || b == VMIN) begin
            res = VMIN;
        end else if (sum[VALUE_WIDTH:VALUE_WIDTH-1] == 2'b01) begin
            res = VMAX;
        end else if (sum[VALUE_WIDTH:VALUE_WIDTH-1] == 2'b10 ||
                     sum[VALUE_WIDTH-1:0] == VMIN) begin
            res = VMIN_FIN;
        end else begin
            res = sum[VALUE_WIDTH-1:0];
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// ----- sv/maxplus_matrix_product_top.sv -----
// Top level of the max-plus matrix product: config registers, beat decode,
// chain of column cells and result drain. Depends on mpp_pkg and mpp_cell.
// A row-closing A beat shows its first result in the cycle after it is accepted.
// Throughput: one B or A beat per cycle; the n_cols results drain one per cycle
// through the cell chain while the output is not stalled, and a row-closing A
// beat waits until that drain is empty. Reset: inner_dim and n_cols return to 8,
// drain chain empties; B store and column maxima are not cleared.
`default_nettype none

module maxplus_matrix_product_top
    import mpp_pkg::*;
#(
    parameter int MAX_DIM = 8
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire t_in_beat             i_in_beat,
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output t_out_beat                 o_out_beat,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [DIM_W-1:0]     i_cfg_data
);

    localparam int LANES = (MAX_DIM < 8) ? MAX_DIM : 8;

    logic [DIM_W-1:0]   r_inner_dim;
    logic [DIM_W-1:0]   r_n_cols;
    logic [DIM_W-1:0]   w_p;
    logic [DIM_W-1:0]   w_q;
    logic [IDX_A_W-1:0] r_row;
    logic               w_is_a;
    logic               w_k_ok;
    logic               w_k_last;
    logic               w_busy;
    logic               w_accept;
    t_cell_ctl          w_ctl;
    t_slot              w_slot [LANES+1];

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inner_dim <= DIM_W'(8);
            r_n_cols    <= DIM_W'(8);
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_INNER_DIM: r_inner_dim <= i_cfg_data;
                CFG_N_COLS:    r_n_cols    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        if (r_inner_dim == '0) begin
            w_p = DIM_W'(1);
        end else if (r_inner_dim > DIM_W'(LANES)) begin
            w_p = DIM_W'(LANES);
        end else begin
            w_p = r_inner_dim;
        end
        if (r_n_cols == '0) begin
            w_q = DIM_W'(1);
        end else if (r_n_cols > DIM_W'(LANES)) begin
            w_q = DIM_W'(LANES);
        end else begin
            w_q = r_n_cols;
        end
    end

    always_comb begin
        w_is_a   = i_in_beat.cmd == CMD_A_ELEM;
        w_k_ok   = {1'b0, i_in_beat.index_b} < w_p;
        w_k_last = {1'b0, i_in_beat.index_b} == (w_p - DIM_W'(1));
        w_busy   = w_slot[0].v;
        o_in_stall = w_busy && w_is_a && w_k_ok && w_k_last;
        w_accept = i_in_valid && !o_in_stall;

        w_ctl.a_en       = w_accept && w_is_a && w_k_ok;
        w_ctl.first      = i_in_beat.index_b == '0;
        w_ctl.drain_load = w_accept && w_is_a && w_k_ok && w_k_last;
        w_ctl.shift      = w_busy && !i_out_stall;
        w_ctl.b_we       = w_accept && !w_is_a && (i_in_beat.index_a < IDX_A_W'(LANES));
        w_ctl.b_col      = i_in_beat.index_b;
        w_ctl.b_row      = i_in_beat.index_a[IDX_B_W-1:0];
        w_ctl.a_k        = i_in_beat.index_b;
        w_ctl.n_cols     = w_q;
    end

    always_ff @(posedge i_clk) begin
        if (w_ctl.drain_load) begin
            r_row <= i_in_beat.index_a;
        end
    end

    assign w_slot[LANES] = '0;

    for (genvar j = 0; j < LANES; j++) begin : g_cell
        mpp_cell #(
            .LANE (j),
            .ROWS (LANES)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_ctl),
            .i_value (i_in_beat.value),
            .i_next  (w_slot[j+1]),
            .o_slot  (w_slot[j])
        );
    end

    always_comb begin
        o_out_valid       = w_slot[0].v;
        o_out_beat.row    = r_row;
        o_out_beat.col    = w_slot[0].col;
        o_out_beat.result = w_slot[0].res;
        o_out_beat.last   = w_slot[0].last;
    end

endmodule

`default_nettype wire

// ----- sv/mpp_cell.sv -----
// One column cell: holds a column of B, the running column maximum and one
// slot of the result drain chain. Depends on mpp_pkg.
`default_nettype none

module mpp_cell
    import mpp_pkg::*;
#(
    parameter int LANE = 0,
    parameter int ROWS = 8
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_cell_ctl i_ctl,
    input  wire t_value    i_value,
    input  wire t_slot     i_next,
    output t_slot          o_slot
);

    localparam int KW = $clog2(ROWS);

    t_value r_bcol [ROWS];
    t_value r_max;
    t_value w_sum;
    t_value n_max;
    t_slot  r_slot;
    t_slot  n_slot;

    always_ff @(posedge i_clk) begin
        if (i_ctl.b_we && i_ctl.b_col == IDX_B_W'(LANE)) begin
            r_bcol[i_ctl.b_row[KW-1:0]] <= i_value;
        end
    end

    always_comb begin
        w_sum = trop_add(i_value, r_bcol[i_ctl.a_k[KW-1:0]]);
        n_max = (i_ctl.first || w_sum > r_max) ? w_sum : r_max;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.a_en) begin
            r_max <= n_max;
        end
    end

    always_comb begin
        if (i_ctl.drain_load) begin
            n_slot.v    = DIM_W'(LANE) < i_ctl.n_cols;
            n_slot.col  = IDX_B_W'(LANE);
            n_slot.last = DIM_W'(LANE + 1) == i_ctl.n_cols;
            n_slot.res  = n_max;
        end else if (i_ctl.shift) begin
            n_slot = i_next;
        end else begin
            n_slot = r_slot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot.v <= 1'b0;
        end else begin
            r_slot <= n_slot;
        end
    end

    assign o_slot = r_slot;

endmodule

`default_nettype wire

// ----- sv/mpp_checker.sv -----
// Port-level checker for the max-plus matrix product top, with its bind.
// Depends on mpp_pkg.
`default_nettype none

module mpp_checker
    import mpp_pkg::*;
(
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      o_out_valid,
    input wire logic      i_out_stall,
    input wire t_out_beat o_out_beat
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_beat))
        else $error("output beat changed while stalled");

    a_col_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_stall && !o_out_beat.last |=>
            o_out_valid &&
            o_out_beat.col == IDX_B_W'($past(o_out_beat.col) + IDX_B_W'(1)))
        else $error("row drain broke column order");

    a_row_same: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_stall && !o_out_beat.last |=>
            o_out_beat.row == $past(o_out_beat.row))
        else $error("row index changed inside a row");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");

endmodule

bind maxplus_matrix_product_top mpp_checker u_mpp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_beat  (o_out_beat)
);

`default_nettype wire

// ----- verif/mpp_product_checker.sv -----
// Checker for the max-plus matrix product: watches the config, input and result
// channels, predicts each row's results and compares them in order.
// Depends on mpp_pkg.
`default_nettype none

module mpp_product_checker
    import mpp_pkg::*;
#(
    parameter int MAX_DIM = 8
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    input  wire logic                 i_in_stall,
    input  wire t_in_beat             i_in_beat,
    input  wire logic                 i_out_valid,
    input  wire logic                 i_out_stall,
    input  wire t_out_beat            i_out_beat,
    input  wire logic                 i_cfg_valid,
    input  wire logic                 i_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [DIM_W-1:0]     i_cfg_data,
    output int                        o_fail_count,
    output int                        o_pending
);

    localparam int LANE_CAP = (MAX_DIM < 8) ? MAX_DIM : 8;

    logic [DIM_W-1:0] inner_reg = 4'd8;
    logic [DIM_W-1:0] ncols_reg = 4'd8;
    t_value           b_mat [MAX_DIM][MAX_DIM];
    t_value           col_peak [MAX_DIM];
    t_out_beat        product_q [$];
    int               fails;

    function automatic int eff_dim(input logic [DIM_W-1:0] r);
        if (r == 0) return 1;
        if (r > LANE_CAP) return LANE_CAP;
        return int'(r);
    endfunction

    function automatic t_value tropical_sum(input t_value a, input t_value b);
        longint s;
        s = longint'(a) + longint'(b);
        if (a == VMIN || b == VMIN) return VMIN;
        if (s > longint'(VMAX)) return VMAX;
        if (s <= longint'(VMIN)) return VMIN_FIN;
        return t_value'(s);
    endfunction

    task automatic fold_beat(input t_in_beat b);
        int        p;
        int        q;
        int        j;
        t_value    s;
        t_out_beat r;
        p = eff_dim(inner_reg);
        q = eff_dim(ncols_reg);
        if (b.cmd == CMD_LOAD_B) begin
            if (b.index_a < MAX_DIM && b.index_b < MAX_DIM) begin
                b_mat[b.index_a[IDX_B_W-1:0]][b.index_b] = b.value;
            end
        end else if (b.index_b < p) begin
            for (j = 0; j < q; j++) begin
                s = tropical_sum(b.value, b_mat[b.index_b][j]);
                if (b.index_b == 0 || s > col_peak[j]) begin
                    col_peak[j] = s;
                end
            end
            if (b.index_b == p - 1) begin
                for (j = 0; j < q; j++) begin
                    r.row    = b.index_a;
                    r.col    = IDX_B_W'(j);
                    r.result = col_peak[j];
                    r.last   = (j == q - 1);
                    product_q.push_back(r);
                end
            end
        end
    endtask

    always @(posedge i_clk) begin
        t_out_beat want;
        if (!i_rst_n) begin
            inner_reg = 4'd8;
            ncols_reg = 4'd8;
            product_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_INNER_DIM: inner_reg = i_cfg_data;
                    CFG_N_COLS:    ncols_reg = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                fold_beat(i_in_beat);
            end
            if (i_out_valid && !i_out_stall) begin
                if (product_q.size() == 0) begin
                    $display("%0t: unexpected beat, expected none, actual %0d/%0d/%0d/%0b",
                             $time, i_out_beat.row, i_out_beat.col,
                             i_out_beat.result, i_out_beat.last);
                    fails++;
                end else begin
                    want = product_q.pop_front();
                    if (want !== i_out_beat) begin
                        $display({"%0t: mismatch row/col/result/last expected ",
                                  "%0d/%0d/%0d/%0b actual %0d/%0d/%0d/%0b"},
                                 $time, want.row, want.col, want.result, want.last,
                                 i_out_beat.row, i_out_beat.col,
                                 i_out_beat.result, i_out_beat.last);
                        fails++;
                    end
                end
            end
        end
        o_pending    <= product_q.size();
        o_fail_count <= fails;
    end

endmodule

`default_nettype wire

// ----- verif/tb_maxplus_matrix_product_top.sv -----
// Testbench top for the max-plus matrix product: clock, reset, stimulus and verdict.
// Depends on mpp_pkg, maxplus_matrix_product_top and mpp_product_checker.
`default_nettype none

module tb_maxplus_matrix_product_top;
    import mpp_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 150;
    localparam int SETTLE_CYCLES = 12;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    t_in_beat             in_beat = '0;
    logic                 in_stall;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    t_out_beat            out_beat;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [DIM_W-1:0]     cfg_data = '0;

    int   fail_count;
    int   pending;
    int   cycle_count = 0;
    int   beats_sent = 0;
    int   src_pct = 0;
    int   sink_pct = 0;
    logic hold_req = 1'b0;

    maxplus_matrix_product_top u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_beat   (in_beat),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_beat  (out_beat),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    mpp_product_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_beat    (in_beat),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_beat   (out_beat),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb_maxplus_matrix_product_top failed");
            $finish;
        end
    end

    // result side: random stall, or a long hold-off on request
    initial begin
        forever begin
            @(negedge clk);
            if (hold_req) begin
                out_stall <= 1'b1;
                hold_req  <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end else begin
                out_stall <= ($urandom_range(99) < sink_pct);
            end
        end
    end

    function automatic t_value pick_value();
        case ($urandom_range(9))
            0:       pick_value = VMIN;
            1:       pick_value = VMAX;
            2:       pick_value = VMIN_FIN;
            3:       pick_value = VMAX - t_value'($urandom_range(1000));
            4:       pick_value = VMIN_FIN + t_value'($urandom_range(1000));
            5, 6:    pick_value = t_value'($urandom_range(200)) - 32'sd100;
            default: pick_value = t_value'($urandom);
        endcase
    endfunction

    // called at a falling edge; returns at the falling edge after the beat is taken
    task automatic send_beat(input t_cmd c, input logic [IDX_A_W-1:0] ia,
                             input logic [IDX_B_W-1:0] ib, input t_value v);
        t_in_beat b;
        b.cmd     = c;
        b.index_a = ia;
        b.index_b = ib;
        b.value   = v;
        while ($urandom_range(99) < src_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_beat  <= b;
        do @(posedge clk); while (in_stall);
        @(negedge clk);
        beats_sent++;
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        wait (pending == 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic apply_dims(input logic [DIM_W-1:0] p_raw, input logic [DIM_W-1:0] q_raw);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_INNER_DIM;
        cfg_data  <= p_raw;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_index <= CFG_N_COLS;
        cfg_data  <= q_raw;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_phase(input int p_raw, input int q_raw, input int src, input int sink,
                             input bit hold, input bit pause, input int n);
        int                 p_eff;
        int                 start;
        int                 pick;
        int                 k;
        bit                 pause_left;
        logic [IDX_A_W-1:0] row_id;
        settle();
        apply_dims(DIM_W'(p_raw), DIM_W'(q_raw));
        p_eff      = (p_raw == 0) ? 1 : ((p_raw > 8) ? 8 : p_raw);
        src_pct    = src;
        sink_pct  <= sink;
        pause_left = pause;
        if (hold) begin
            hold_req <= 1'b1;
        end
        start = beats_sent;
        while (beats_sent - start < n) begin
            if (pause_left && beats_sent - start >= n / 2) begin
                pause_left = 1'b0;
                settle();
            end
            pick   = $urandom_range(99);
            row_id = IDX_A_W'($urandom_range(255));
            if (pick < 8) begin
                send_beat(CMD_LOAD_B, IDX_A_W'($urandom_range(7)),
                          IDX_B_W'($urandom_range(7)), pick_value());
            end else if (pick < 12) begin
                send_beat(CMD_LOAD_B, IDX_A_W'($urandom_range(255, 8)),
                          IDX_B_W'($urandom_range(7)), pick_value());
            end else if (pick < 16 && p_eff < 8) begin
                send_beat(CMD_A_ELEM, row_id, IDX_B_W'($urandom_range(7, p_eff)),
                          pick_value());
            end else if (pick < 28) begin
                // restart at k = 0, stray inner indexes, maybe never closed
                send_beat(CMD_A_ELEM, row_id, 3'd0, pick_value());
                if (p_eff > 2) begin
                    repeat ($urandom_range(3)) begin
                        send_beat(CMD_A_ELEM, IDX_A_W'($urandom_range(255)),
                                  IDX_B_W'($urandom_range(p_eff - 2, 1)), pick_value());
                    end
                end
                if (p_eff > 1 && $urandom_range(1) == 1) begin
                    send_beat(CMD_A_ELEM, row_id, IDX_B_W'(p_eff - 1), pick_value());
                end
            end else begin
                for (k = 0; k < p_eff; k++) begin
                    send_beat(CMD_A_ELEM, row_id, IDX_B_W'(k), pick_value());
                end
            end
        end
    endtask

    initial begin
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int k = 0; k < 8; k++) begin
            for (int j = 0; j < 8; j++) begin
                send_beat(CMD_LOAD_B, IDX_A_W'(k), IDX_B_W'(j), pick_value());
            end
        end

        // reset dims; epsilon, saturation both ways, out-of-range loads
        send_beat(CMD_LOAD_B, 8'd0, 3'd0, VMAX);
        send_beat(CMD_LOAD_B, 8'd0, 3'd1, VMIN);
        send_beat(CMD_LOAD_B, 8'd0, 3'd2, VMIN_FIN);
        send_beat(CMD_LOAD_B, 8'd0, 3'd3, 32'sd0);
        send_beat(CMD_LOAD_B, 8'd8, 3'd4, VMAX);
        send_beat(CMD_LOAD_B, 8'd255, 3'd7, VMIN);
        send_beat(CMD_A_ELEM, 8'd255, 3'd0, VMAX);
        send_beat(CMD_A_ELEM, 8'd255, 3'd1, VMIN);
        send_beat(CMD_A_ELEM, 8'd255, 3'd2, VMIN_FIN);
        send_beat(CMD_A_ELEM, 8'd255, 3'd3, -32'sd1);
        send_beat(CMD_A_ELEM, 8'd255, 3'd4, 32'sd0);
        send_beat(CMD_A_ELEM, 8'd255, 3'd5, 32'sd1);
        send_beat(CMD_A_ELEM, 8'd255, 3'd6, VMAX);
        send_beat(CMD_A_ELEM, 8'd255, 3'd7, VMIN);

        // dims clamp to 1 and 8; inner index past inner_dim is dropped
        settle();
        apply_dims(4'd0, 4'd15);
        send_beat(CMD_A_ELEM, 8'd0, 3'd0, VMIN_FIN);
        send_beat(CMD_A_ELEM, 8'd7, 3'd3, 32'sd5);
        send_beat(CMD_A_ELEM, 8'd128, 3'd0, -32'sd1);
        send_beat(CMD_A_ELEM, 8'd1, 3'd0, VMIN);

        run_phase(8, 8, 0, 0, 1'b0, 1'b0, 10);
        run_phase(1, 8, 0, 0, 1'b1, 1'b0, 10);
        run_phase(8, 1, 52, 0, 1'b0, 1'b0, 10);
        run_phase($urandom_range(15), $urandom_range(15), 0, 52, 1'b0, 1'b1, 10);
        run_phase($urandom_range(15), $urandom_range(15), 38, 38, 1'b0, 1'b0, 10);
        run_phase(2, 3, 52, 0, 1'b0, 1'b0, 10);
        run_phase($urandom_range(15), $urandom_range(15), 0, 52, 1'b0, 1'b0, 10);
        run_phase($urandom_range(15), $urandom_range(15), 38, 38, 1'b0, 1'b0, 10);

        in_valid <= 1'b0;
        wait (pending == 0);
        repeat (20) @(posedge clk);
        if (fail_count == 0) begin
            $display("tb_maxplus_matrix_product_top passed");
        end else begin
            $display("tb_maxplus_matrix_product_top failed");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ----- maxplus_matrix_product_top.f -----
sv/mpp_pkg.sv
sv/mpp_cell.sv
sv/maxplus_matrix_product_top.sv
sv/mpp_checker.sv
verif/mpp_product_checker.sv
verif/tb_maxplus_matrix_product_top.sv
